>>> hdl/snnq_pkg.sv
// shared types, constants and register codes for the snn similarity query block
package snnq_pkg;

    localparam int unsigned POINTS_DEF        = 256;
    localparam int unsigned MAX_NEIGHBORS_DEF = 32;

    localparam int unsigned ROW_W     = 8;
    localparam int unsigned SLOT_W    = 5;
    localparam int unsigned NBR_W     = 8;
    localparam int unsigned KREQ_W    = 6;
    localparam int unsigned COUNT_W   = 11;
    localparam int unsigned SIM_W     = 17;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 17;

    localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << FRAC_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_K_REQUESTED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRUNE_THRESHOLD = 2'd2;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ROW_W-1:0]  row_a;
        logic [SLOT_W-1:0] slot;
        logic [NBR_W-1:0]  neighbour_index;
        logic [ROW_W-1:0]  row_b;
    } snnq_req_t;

    typedef struct packed {
        logic               is_query_answer;
        logic [COUNT_W-1:0] shared_count;
        logic [SIM_W-1:0]   similarity;
        logic               was_pruned;
        logic               saturated;
    } snnq_rsp_t;

endpackage

>>> hdl/snnq_if.sv
// request and response stream interfaces
interface snnq_req_if
    import snnq_pkg::*;
();
    logic      valid;
    logic      ready;
    snnq_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface snnq_rsp_if
    import snnq_pkg::*;
();
    logic      valid;
    logic      ready;
    snnq_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/snn_similarity_query.sv
// top level: neighbour table, shared-neighbour count sequencer and serial divider
//
//  channel   dir   handshake           payload
//  req       in    req.valid/ready     operation, row_a, slot, neighbour_index, row_b
//  rsp       out   rsp.valid/ready     is_query_answer, shared_count, similarity, flags
//  cfg       in    cfg_wr_en           cfg_index, cfg_data
//
// a write goes straight to the finish state; a query reads the table one word at a time:
// the table has one read port, so every slot pair costs one read, plus one read per row-a
// slot, then a 17-step restoring divide.
// rst_n clears control state only; the table holds garbage until written.
// req is taken only while the sequencer is idle; one finished result may wait in
// the output register while the next item is worked on.
module snn_similarity_query
    import snnq_pkg::*;
#(
    parameter int unsigned POINTS        = POINTS_DEF,
    parameter int unsigned MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    snnq_req_if.sink             req,
    snnq_rsp_if.source           rsp,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int unsigned DEPTH  = POINTS * MAX_NEIGHBORS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned KW     = $clog2(MAX_NEIGHBORS + 1);
    localparam int unsigned IDX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int unsigned S_W    = $clog2(MAX_NEIGHBORS * MAX_NEIGHBORS + 1);
    localparam int unsigned D_W    = KW + 1;
    localparam int unsigned R_W    = D_W + 1;
    localparam int unsigned W_W    = ((S_W > R_W) ? S_W : R_W) + 1;
    localparam int unsigned STEP_W = $clog2(FRAC_BITS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_SETUP  = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [KREQ_W-1:0]   k_req_reg;
    logic [SLOT_W-1:0]   first_slot_reg;
    logic [SIM_W-1:0]    threshold_reg;

    logic                op_reg;
    logic [KW-1:0]       k_reg;
    logic [ADDR_W-1:0]   base_a_reg, base_b_reg;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic                phase_a_reg, phase_a_next;
    logic                rd_valid_reg;
    logic                rd_is_a_reg;
    logic [NBR_W-1:0]    va_reg;
    logic [S_W-1:0]      count_reg;
    logic [D_W-1:0]      d_reg;
    logic [R_W-1:0]      r_reg;
    logic [SIM_W-1:0]    q_reg;
    logic                sat_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    snnq_rsp_t           rsp_data_reg;

    logic                accept;
    logic [KW-1:0]       k_win;
    logic                rows_ok;
    logic                wr_ok;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [NBR_W-1:0]    rd_data;
    logic [KW-1:0]       k_last;
    logic                out_load;

    // setup and divide step
    logic [W_W-1:0]      s_w, k_w, d_w, r0_w;
    logic                q0;
    logic [R_W-1:0]      r2;
    logic                ge;
    logic [SIM_W-1:0]    sim_raw;
    logic                pruned;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // active window size from the registers
    always_comb
    begin
        logic [9:0] kr;
        logic [9:0] fs;
        logic [9:0] mx;
        logic [9:0] kc;
        kr = 10'(k_req_reg);
        fs = 10'(first_slot_reg);
        mx = 10'(MAX_NEIGHBORS);
        kc = (kr == 10'd0 || kr > mx) ? mx : kr;
        if (fs + kc > mx)
        begin
            kc = (fs >= mx) ? 10'd0 : mx - fs;
        end
        k_win = KW'(kc);
    end

    assign rows_ok = (17'(req.data.row_a) < 17'(POINTS)) && (17'(req.data.row_b) < 17'(POINTS));
    assign wr_ok   = (17'(req.data.row_a) < 17'(POINTS))
                  && (9'(req.data.slot) < 9'(MAX_NEIGHBORS));
    assign wr_addr = ADDR_W'(ADDR_W'(req.data.row_a) * ADDR_W'(MAX_NEIGHBORS))
                   + ADDR_W'(req.data.slot);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_req_reg      <= '0;
            first_slot_reg <= '0;
            threshold_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_K_REQUESTED:     k_req_reg      <= cfg_data[KREQ_W-1:0];
                CFG_FIRST_SLOT:      first_slot_reg <= cfg_data[SLOT_W-1:0];
                CFG_PRUNE_THRESHOLD: threshold_reg  <= cfg_data[SIM_W-1:0];
                default:             ;
            endcase
        end
    end

    snnq_ram #(
        .WIDTH (NBR_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (accept && req.data.operation == OP_WRITE && wr_ok),
        .wr_addr (wr_addr),
        .wr_data (req.data.neighbour_index),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // read issue: one row-a slot, then every row-b slot of the window
    assign k_last  = KW'(k_reg - 1'b1);
    assign rd_en   = (state_reg == ST_READ);
    assign rd_addr = phase_a_reg ? base_a_reg + ADDR_W'(i_reg) : base_b_reg + ADDR_W'(j_reg);

    // divider setup and step
    always_comb
    begin
        s_w  = W_W'(count_reg);
        k_w  = W_W'(k_reg);
        d_w  = W_W'({k_w, 1'b0}) - s_w;
        q0   = (s_w >= d_w);
        r0_w = q0 ? s_w - d_w : s_w;
        r2   = {r_reg[R_W-2:0], 1'b0};
        ge   = (r2 >= R_W'(d_reg));
    end

    always_comb
    begin
        if (k_reg == '0)
        begin
            sim_raw = '0;
        end
        else if (sat_reg)
        begin
            sim_raw = SIM_ONE;
        end
        else
        begin
            sim_raw = q_reg;
        end
        pruned = (threshold_reg != '0) && (sim_raw <= threshold_reg);
    end

    assign out_load = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        phase_a_next = phase_a_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next       = '0;
                j_next       = '0;
                phase_a_next = 1'b1;
                if (accept)
                begin
                    if (req.data.operation == OP_WRITE)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (rows_ok && k_win != '0)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_READ:
            begin
                if (phase_a_reg)
                begin
                    phase_a_next = 1'b0;
                    j_next       = '0;
                end
                else if (j_reg == IDX_W'(k_last))
                begin
                    if (i_reg == IDX_W'(k_last))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        i_next       = i_reg + 1'b1;
                        phase_a_next = 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:  state_next = ST_SETUP;
            ST_SETUP:  state_next = (k_reg != '0 && !(s_w > k_w)) ? ST_DIV : ST_FINISH;
            ST_DIV:
            begin
                if (step_reg == STEP_W'(FRAC_BITS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            phase_a_reg   <= 1'b1;
            rd_valid_reg  <= 1'b0;
            rd_is_a_reg   <= 1'b0;
            count_reg     <= '0;
            step_reg      <= '0;
            sat_reg       <= 1'b0;
            op_reg        <= OP_WRITE;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            phase_a_reg   <= phase_a_next;
            rd_valid_reg  <= rd_en;
            rd_is_a_reg   <= phase_a_reg;
            rsp_valid_reg <= rsp_valid_next;

            if (accept)
            begin
                op_reg    <= req.data.operation;
                k_reg     <= k_win;
                count_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else if (rd_valid_reg && !rd_is_a_reg && rd_data == va_reg)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (state_reg == ST_SETUP)
            begin
                sat_reg  <= (k_reg != '0) && (s_w > k_w);
                step_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_a_reg <= ADDR_W'(ADDR_W'(req.data.row_a) * ADDR_W'(MAX_NEIGHBORS))
                        + ADDR_W'(first_slot_reg);
            base_b_reg <= ADDR_W'(ADDR_W'(req.data.row_b) * ADDR_W'(MAX_NEIGHBORS))
                        + ADDR_W'(first_slot_reg);
        end
        if (rd_valid_reg && rd_is_a_reg)
        begin
            va_reg <= rd_data;
        end
        if (state_reg == ST_SETUP)
        begin
            d_reg <= D_W'(d_w);
            r_reg <= R_W'(r0_w);
            q_reg <= SIM_W'(q0);
        end
        else if (state_reg == ST_DIV)
        begin
            r_reg <= ge ? r2 - R_W'(d_reg) : r2;
            q_reg <= {q_reg[SIM_W-2:0], ge};
        end
        if (out_load)
        begin
            if (op_reg == OP_WRITE)
            begin
                rsp_data_reg <= '0;
            end
            else
            begin
                rsp_data_reg.is_query_answer <= 1'b1;
                rsp_data_reg.shared_count    <= COUNT_W'(count_reg);
                rsp_data_reg.similarity      <= pruned ? '0 : sim_raw;
                rsp_data_reg.was_pruned      <= pruned;
                rsp_data_reg.saturated       <= sat_reg;
            end
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

>>> hdl/snnq_ram.sv
// generic single-write, single-read ram with registered read data
module snnq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sim/testbench.sv
// self-checking testbench for snn_similarity_query: random write and query streams against a predictor
class answer_scoreboard;
    bit [snnq_pkg::NBR_W-1:0] nbr_mem [snnq_pkg::POINTS_DEF][snnq_pkg::MAX_NEIGHBORS_DEF];
    bit written_slot [snnq_pkg::POINTS_DEF][snnq_pkg::MAX_NEIGHBORS_DEF];
    bit [snnq_pkg::KREQ_W-1:0] k_req;
    bit [snnq_pkg::SLOT_W-1:0] first_slot;
    bit [snnq_pkg::SIM_W-1:0]  prune_level;
    snnq_pkg::snnq_rsp_t pending_answers[$];
    int unsigned mismatches;

    function void set_register(logic [snnq_pkg::CFG_IDX_W-1:0] index,
                               logic [snnq_pkg::CFG_W-1:0] value);
        case (index)
            snnq_pkg::CFG_K_REQUESTED:     k_req = value[snnq_pkg::KREQ_W-1:0];
            snnq_pkg::CFG_FIRST_SLOT:      first_slot = value[snnq_pkg::SLOT_W-1:0];
            snnq_pkg::CFG_PRUNE_THRESHOLD: prune_level = value[snnq_pkg::SIM_W-1:0];
            default: ;
        endcase
    endfunction

    // neighbours compared per row after clamping to the stored columns
    function int unsigned window_size();
        int unsigned k;
        k = k_req;
        if (k == 0 || k > snnq_pkg::MAX_NEIGHBORS_DEF)
            k = snnq_pkg::MAX_NEIGHBORS_DEF;
        if (first_slot + k > snnq_pkg::MAX_NEIGHBORS_DEF)
            k = snnq_pkg::MAX_NEIGHBORS_DEF - first_slot;
        return k;
    endfunction

    function bit window_filled(int unsigned row);
        int unsigned k, i;
        k = window_size();
        for (i = 0; i < k; i++)
            if (!written_slot[row][first_slot + i])
                return 1'b0;
        return 1'b1;
    endfunction

    function void note_request(snnq_pkg::snnq_req_t item);
        snnq_pkg::snnq_rsp_t answer;
        int unsigned k, shared, quotient, i, j;
        answer = '0;
        if (item.operation == snnq_pkg::OP_WRITE) begin
            nbr_mem[item.row_a][item.slot] = item.neighbour_index;
            written_slot[item.row_a][item.slot] = 1'b1;
        end else begin
            k = window_size();
            shared = 0;
            for (i = 0; i < k; i++)
                for (j = 0; j < k; j++)
                    if (nbr_mem[item.row_a][first_slot + i] == nbr_mem[item.row_b][first_slot + j])
                        shared++;
            quotient = 0;
            if (k != 0) begin
                // duplicate neighbours push the ratio past one
                if (shared > k) begin
                    quotient = snnq_pkg::SIM_ONE;
                    answer.saturated = 1'b1;
                end else begin
                    quotient = (shared << snnq_pkg::FRAC_BITS) / (2 * k - shared);
                end
            end
            if (prune_level != 0 && quotient <= prune_level) begin
                quotient = 0;
                answer.was_pruned = 1'b1;
            end
            answer.is_query_answer = 1'b1;
            answer.shared_count = snnq_pkg::COUNT_W'(shared);
            answer.similarity = snnq_pkg::SIM_W'(quotient);
        end
        pending_answers = {pending_answers, answer};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(snnq_pkg::snnq_rsp_t got);
        snnq_pkg::snnq_rsp_t want;
        if (pending_answers.size() == 0) begin
            $error("answer with nothing outstanding: %p", got);
            mismatches++;
            return;
        end
        want = pending_answers.pop_front();
        compare_field("is_query_answer", want.is_query_answer, got.is_query_answer);
        compare_field("shared_count", want.shared_count, got.shared_count);
        compare_field("similarity", want.similarity, got.similarity);
        compare_field("was_pruned", want.was_pruned, got.was_pruned);
        compare_field("saturated", want.saturated, got.saturated);
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import snnq_pkg::*;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned TOTAL_ITEMS   = 560;
    localparam int unsigned HOLD_CYCLES   = 3000;
    localparam int unsigned SETTLE_CYCLES = 30;
    // slowest gap between transfers: a full-width query plus stalls, plus the long hold
    localparam int unsigned IDLE_LIMIT    = 20000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    snnq_req_if req_if();
    snnq_rsp_if rsp_if();

    answer_scoreboard board = new;

    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    bit          hold_rsp = 1'b0;
    logic [7:0]  value_base = '0;
    int unsigned touched_rows[$];

    snn_similarity_query dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic send_item(input snnq_req_t item);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 20);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        items_sent++;
        board.note_request(item);
    endtask

    task automatic send_write(input int unsigned row, input int unsigned slot,
                              input int unsigned value);
        snnq_req_t item;
        item.operation = OP_WRITE;
        item.row_a = ROW_W'(row);
        item.slot = SLOT_W'(slot);
        item.neighbour_index = NBR_W'(value);
        item.row_b = ROW_W'($urandom_range(0, 255));
        touched_rows = {touched_rows, row};
        send_item(item);
    endtask

    // slot and neighbour_index are don't-care for a query, so they get noise
    task automatic send_query(input int unsigned row_first, input int unsigned row_second);
        snnq_req_t item;
        item.operation = OP_QUERY;
        item.row_a = ROW_W'(row_first);
        item.slot = SLOT_W'($urandom_range(0, 31));
        item.neighbour_index = NBR_W'($urandom_range(0, 255));
        item.row_b = ROW_W'(row_second);
        send_item(item);
    endtask

    task automatic pause_until_idle();
        req_if.valid <= 1'b0;
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        board.set_register(index, CFG_W'(value));
    endtask

    task automatic set_config(input int unsigned k, input int unsigned first,
                              input int unsigned level);
        pause_until_idle();
        write_register(CFG_K_REQUESTED, k);
        write_register(CFG_FIRST_SLOT, first);
        write_register(CFG_PRUNE_THRESHOLD, level);
        cfg_wr_en <= 1'b0;
    endtask

    // writes the active window of a row; a partial fill stops early
    task automatic fill_row(input int unsigned row, input bit partial);
        int unsigned k, count, span, i;
        k = board.window_size();
        count = partial ? $urandom_range(1, k) : k;
        case ($urandom_range(0, 3))
            0:       span = 0;
            1:       span = 3;
            2:       span = 15;
            default: span = 255;
        endcase
        for (i = 0; i < count; i++)
            send_write(row, board.first_slot + i, value_base + $urandom_range(0, span));
    endtask

    task automatic random_step();
        int unsigned ready_rows[$];
        int unsigned pick, row_first, row_second, row;
        pick = $urandom_range(0, 99);
        foreach (touched_rows[n])
            if (board.window_filled(touched_rows[n]))
                ready_rows = {ready_rows, touched_rows[n]};
        if (pick < 12) begin
            send_write($urandom_range(0, 255), $urandom_range(0, 31), $urandom_range(0, 255));
        end else if (pick < 35 || ready_rows.size() == 0) begin
            if (touched_rows.size() != 0 && $urandom_range(0, 1) == 1)
                row = touched_rows[$urandom_range(0, touched_rows.size() - 1)];
            else
                row = $urandom_range(0, 255);
            fill_row(row, $urandom_range(0, 5) == 0);
        end else begin
            row_first = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
            if ($urandom_range(0, 3) == 0)
                row_second = row_first;
            else
                row_second = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
            send_query(row_first, row_second);
        end
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned target;
        target = items_sent + budget;
        while (items_sent < target && items_sent < TOTAL_ITEMS)
            random_step();
    endtask

    initial begin
        int unsigned phase, k, first, level;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // four-wide window, distinct and shared values, plus a row of duplicates
        set_config(4, 0, 0);
        send_write(0, 0, 8'h00);
        send_write(0, 1, 8'hFF);
        send_write(0, 2, 8'h55);
        send_write(0, 3, 8'hAA);
        send_write(255, 0, 8'hFF);
        send_write(255, 1, 8'h00);
        send_write(255, 2, 8'h55);
        send_write(255, 3, 8'h13);
        send_write(8'h5A, 0, 8'h77);
        send_write(8'h5A, 1, 8'h77);
        send_write(8'h5A, 2, 8'h77);
        send_write(8'h5A, 3, 8'h77);
        send_query(0, 255);
        send_query(0, 0);
        send_query(8'h5A, 8'h5A);
        send_query(8'h5A, 0);

        // pruning at the threshold itself and with nothing shared
        set_config(4, 0, 39321);
        send_query(0, 255);
        send_query(0, 0);
        send_query(8'h5A, 0);

        // oversized k clamped, window cut at the last slot, threshold at one
        set_config(63, 28, SIM_ONE);
        send_write(8'hA5, 28, 8'h01);
        send_write(8'hA5, 29, 8'h80);
        send_write(8'hA5, 30, 8'h01);
        send_write(8'hA5, 31, 8'hFE);
        send_query(8'hA5, 8'hA5);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            case (phase)
                0: set_config(0, 30, 0);
                1:
                begin
                    set_config(63, 31, 1);
                    hold_rsp = 1'b1;
                end
                2: set_config(32, 0, 0);
                3: set_config(1, 0, SIM_ONE);
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       k = 0;
                        1:       k = $urandom_range(33, 63);
                        default: k = $urandom_range(1, 8);
                    endcase
                    first = (k == 0 || k > 32) ? $urandom_range(24, 31) : $urandom_range(0, 31);
                    case ($urandom_range(0, 2))
                        0:       level = 0;
                        1:       level = 32768;
                        default: level = $urandom_range(1, 65536);
                    endcase
                    set_config(k, first, level);
                end
            endcase
            value_base = 8'($urandom_range(0, 255));
            run_phase(phase == 2 ? 90 : $urandom_range(30, 60));
            phase++;
        end

        req_if.valid <= 1'b0;
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending_answers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // response side back-pressure: stretches of free flow, coin flips, a fixed pattern, bursts
    initial begin
        int unsigned mode, stretch, stall_left;
        rsp_if.ready <= 1'b0;
        mode = 0;
        stretch = 0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_rsp) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode = $urandom_range(0, 3);
                    stretch = $urandom_range(20, 300);
                end
                stretch--;
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= 1'($urandom_range(0, 1));
                    2: rsp_if.ready <= (stretch % 4) != 0;
                    default:
                    begin
                        if (stall_left == 0 && $urandom_range(0, 7) == 0)
                            stall_left = $urandom_range(1, 12);
                        if (stall_left != 0) begin
                            stall_left--;
                            rsp_if.ready <= 1'b0;
                        end else begin
                            rsp_if.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.data);
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end
endmodule

>>> snn_similarity_query.f
hdl/snnq_pkg.sv
hdl/snnq_if.sv
hdl/snnq_ram.sv
hdl/snn_similarity_query.sv
sim/testbench.sv
